[hw/rtl/smrp_pkg.sv]
// Package for the sorted multiset with random pick.
// Holds the operation codes, the controller state type and the fixed field widths.
// No dependencies.
package smrp_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DIVIDEND_W = 31;
  localparam int unsigned DIV_STEP_W = $clog2(DIVIDEND_W);

  // Operation codes carried by the kind field.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PICK   = 2'd2
  } kind_e;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SRCH_RD  = 9'b000000010,
    ST_SRCH_CMP = 9'b000000100,
    ST_SHIFT_UP = 9'b000001000,
    ST_PLACE    = 9'b000010000,
    ST_SHIFT_DN = 9'b000100000,
    ST_MOD_WAIT = 9'b001000000,
    ST_PICK_RD  = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_e;

endpackage

[hw/rtl/sorted_multiset_random_pick_core.sv]
// Sorted multiset with random pick: one item at a time, one result per item.
// Insert/remove: a binary search over the store's read port, then the affected entries
// are shifted one at a time, plus the control states.
// Pick: the bit-serial remainder unit gives an index, then the chosen entry is read.
// A finished result waits in an output register while the next item is taken.
// Reset clears the entry count and control state; the store needs no clearing.
module sorted_multiset_random_pick_core #(
  parameter int unsigned CAPACITY = 256,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1),
  localparam int unsigned AddrW   = $clog2(CAPACITY)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             kind_i,
  input  logic signed [smrp_pkg::VALUE_W-1:0]    value_i,
  input  logic [smrp_pkg::DIVIDEND_W-1:0]        random_number_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   success_flag_o,
  output logic signed [smrp_pkg::VALUE_W-1:0]    picked_value_o,
  output logic                                   full_reject_o,
  output logic [CntW-1:0]                        entry_count_o
);

  smrp_pkg::state_e state_q, state_d;
  smrp_pkg::kind_e  kind_q, kind_d;

  logic                             in_accept;
  logic [CntW-1:0]                  count_q, count_d;
  logic [CntW-1:0]                  lo_q, lo_d;
  logic [CntW-1:0]                  hi_q, hi_d;
  logic [AddrW-1:0]                 mid_q, mid_d;
  logic [CntW-1:0]                  idx_q, idx_d;
  logic                             eq_q, eq_d;
  logic                             wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]                 wr_addr_q, wr_addr_d;
  logic signed [smrp_pkg::VALUE_W-1:0] key_q, key_d;
  logic                             succ_q, succ_d;
  logic                             rej_q, rej_d;
  logic [smrp_pkg::VALUE_W-1:0]     pick_q, pick_d;

  logic                             out_valid_q, out_valid_d;
  logic                             out_succ_q;
  logic [smrp_pkg::VALUE_W-1:0]     out_pick_q;
  logic                             out_rej_q;
  logic [CntW-1:0]                  out_count_q;
  logic                             out_load;

  logic [CntW:0]                    mid_sum;
  logic [CntW-1:0]                  idx_m1;
  logic [CntW:0]                    idx_p1;

  logic                             mem_we;
  logic [AddrW-1:0]                 mem_waddr;
  logic [smrp_pkg::VALUE_W-1:0]     mem_wdata;
  logic                             mem_re;
  logic [AddrW-1:0]                 mem_raddr;
  logic [smrp_pkg::VALUE_W-1:0]     mem_rdata;

  logic                             mod_start;
  logic                             mod_done;
  logic [CntW-1:0]                  mod_rem;

  // Entry store.
  smrp_store #(
    .DEPTH (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Remainder unit for the pick index.
  smrp_mod #(
    .CntW (CntW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (random_number_i),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign in_stall_o = (state_q != smrp_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign idx_m1  = idx_q - CntW'(1);
  assign idx_p1  = {1'b0, idx_q} + (CntW + 1)'(1);

  // The output register takes a new result when it is empty or being drained.
  assign out_load = (state_q == smrp_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);

  // Controller: search, shift, place and pick sequencing.
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    idx_d     = idx_q;
    eq_d      = eq_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    key_d     = key_q;
    succ_d    = succ_q;
    rej_d     = rej_q;
    pick_d    = pick_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = mid_q;
    mod_start = 1'b0;

    unique case (state_q)
      smrp_pkg::ST_IDLE: begin
        if (in_accept) begin
          kind_d    = smrp_pkg::kind_e'(kind_i);
          key_d     = value_i;
          succ_d    = 1'b0;
          rej_d     = 1'b0;
          pick_d    = '0;
          eq_d      = 1'b0;
          wr_pend_d = 1'b0;
          lo_d      = '0;
          hi_d      = count_q;
          unique case (kind_i)
            smrp_pkg::KIND_INSERT: begin
              if (count_q == CntW'(CAPACITY)) begin
                rej_d   = 1'b1;
                state_d = smrp_pkg::ST_FINISH;
              end else begin
                state_d = smrp_pkg::ST_SRCH_RD;
              end
            end
            smrp_pkg::KIND_REMOVE: begin
              state_d = smrp_pkg::ST_SRCH_RD;
            end
            smrp_pkg::KIND_PICK: begin
              if (count_q == '0) begin
                state_d = smrp_pkg::ST_FINISH;
              end else begin
                succ_d    = 1'b1;
                mod_start = 1'b1;
                state_d   = smrp_pkg::ST_MOD_WAIT;
              end
            end
            default: begin
              state_d = smrp_pkg::ST_FINISH;
            end
          endcase
        end
      end

      // Issue the read of the middle entry, or end the search.
      smrp_pkg::ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          mem_re    = 1'b1;
          mem_raddr = mid_sum[AddrW:1];
          mid_d     = mid_sum[AddrW:1];
          state_d   = smrp_pkg::ST_SRCH_CMP;
        end else if (kind_q == smrp_pkg::KIND_INSERT) begin
          succ_d  = !eq_q;
          idx_d   = count_q;
          state_d = smrp_pkg::ST_SHIFT_UP;
        end else if (eq_q) begin
          succ_d  = 1'b1;
          idx_d   = lo_q;
          state_d = smrp_pkg::ST_SHIFT_DN;
        end else begin
          state_d = smrp_pkg::ST_FINISH;
        end
      end

      // Narrow the interval; the last upper bound tells whether the key is present.
      smrp_pkg::ST_SRCH_CMP: begin
        if ($signed(mem_rdata) < key_q) begin
          lo_d = CntW'(mid_q) + CntW'(1);
        end else begin
          hi_d = CntW'(mid_q);
          eq_d = ($signed(mem_rdata) == key_q);
        end
        state_d = smrp_pkg::ST_SRCH_RD;
      end

      // Move entries up one place, top first: read one, write the previous.
      smrp_pkg::ST_SHIFT_UP: begin
        mem_we = wr_pend_q;
        if (idx_q != lo_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_m1[AddrW-1:0];
          wr_addr_d = idx_q[AddrW-1:0];
          idx_d     = idx_m1;
          wr_pend_d = 1'b1;
        end else begin
          wr_pend_d = 1'b0;
          state_d   = smrp_pkg::ST_PLACE;
        end
      end

      // Store the new value in the freed place.
      smrp_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AddrW-1:0];
        mem_wdata = key_q;
        count_d   = count_q + CntW'(1);
        state_d   = smrp_pkg::ST_FINISH;
      end

      // Move entries down one place over the removed one.
      smrp_pkg::ST_SHIFT_DN: begin
        mem_we = wr_pend_q;
        if (idx_p1 < {1'b0, count_q}) begin
          mem_re    = 1'b1;
          mem_raddr = idx_p1[AddrW-1:0];
          wr_addr_d = idx_q[AddrW-1:0];
          idx_d     = idx_p1[CntW-1:0];
          wr_pend_d = 1'b1;
        end else begin
          wr_pend_d = 1'b0;
          count_d   = count_q - CntW'(1);
          state_d   = smrp_pkg::ST_FINISH;
        end
      end

      // Wait for the index, then read the chosen entry.
      smrp_pkg::ST_MOD_WAIT: begin
        if (mod_done) begin
          mem_re    = 1'b1;
          mem_raddr = mod_rem[AddrW-1:0];
          state_d   = smrp_pkg::ST_PICK_RD;
        end
      end

      smrp_pkg::ST_PICK_RD: begin
        pick_d  = mem_rdata;
        state_d = smrp_pkg::ST_FINISH;
      end

      // Hand the result to the output register.
      smrp_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = smrp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = smrp_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smrp_pkg::ST_IDLE;
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    idx_q     <= idx_d;
    eq_q      <= eq_d;
    wr_addr_q <= wr_addr_d;
    key_q     <= key_d;
    succ_q    <= succ_d;
    rej_q     <= rej_d;
    pick_q    <= pick_d;
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_succ_q  <= succ_q;
      out_pick_q  <= pick_q;
      out_rej_q   <= rej_q;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign success_flag_o = out_succ_q;
  assign picked_value_o = out_pick_q;
  assign full_reject_o  = out_rej_q;
  assign entry_count_o  = out_count_q;

`ifndef SYNTHESIS
  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The count changes only when a value is placed or a removal completes.
  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == smrp_pkg::ST_PLACE ||
                           $past(state_q) == smrp_pkg::ST_SHIFT_DN))
    else $error("entry count changed outside place or removal");

  // The store is never written while the block waits for an item.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smrp_pkg::ST_IDLE |-> !mem_we)
    else $error("store written while idle");

  // A refused insert reports a full store and no success.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_reject_o |-> !success_flag_o && entry_count_o == CntW'(CAPACITY))
    else $error("refused insert with inconsistent result");

  // A nonzero picked value only comes with success.
  a_pick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_flag_o |-> picked_value_o == '0)
    else $error("picked value set without success");
`endif

endmodule

[hw/rtl/smrp_store.sv]
// Entry store of the sorted multiset: one write port, one read port.
// The read data is registered.
// Depends on smrp_pkg for the entry width.
module smrp_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [smrp_pkg::VALUE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [smrp_pkg::VALUE_W-1:0] rdata_o
);

  logic [smrp_pkg::VALUE_W-1:0] mem_q [DEPTH];
  logic [smrp_pkg::VALUE_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/smrp_mod.sv]
// Iterative restoring remainder unit: one dividend bit per cycle.
// Computes dividend modulo a nonzero divisor.
// Depends on smrp_pkg for the dividend width.
module smrp_mod #(
  parameter int unsigned CntW = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [smrp_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [CntW-1:0]                divisor_i,
  output logic                           done_o,
  output logic [CntW-1:0]                rem_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [smrp_pkg::DIV_STEP_W-1:0] cnt_q, cnt_d;
  logic [smrp_pkg::DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [CntW-1:0]                 div_q, div_d;
  logic [CntW-1:0]                 rem_q, rem_d;
  logic [CntW:0]                   trial;
  logic [CntW:0]                   trial_sub;

  // One restoring step: bring down the next bit and subtract if possible.
  assign trial     = {rem_q, dvd_q[smrp_pkg::DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = smrp_pkg::DIV_STEP_W'(smrp_pkg::DIVIDEND_W - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, div_q}) ? trial_sub[CntW-1:0] : trial[CntW-1:0];
      dvd_d = {dvd_q[smrp_pkg::DIVIDEND_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - smrp_pkg::DIV_STEP_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
